### rtl/ifd_pkg.sv
`timescale 1ns / 1ps
package ifd_pkg;

  localparam int FIELD_MAX    = 128;
  localparam int FIELD_COUNT_DEF = 128;
  localparam int BITMAP_BYTES = 8;
  localparam int HDR_W        = 6;
  localparam logic [HDR_W-1:0] HDR_RESET = 6'd15;
  localparam int LEN_W        = 14;
  localparam logic [LEN_W-1:0] LEN_MAX = 14'd16383;
  localparam int QUEUE_DEPTH  = 4;

  // parse phases
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_HEADER    = 3'd1;
  localparam logic [2:0] PH_PRIMARY   = 3'd2;
  localparam logic [2:0] PH_SECONDARY = 3'd3;
  localparam logic [2:0] PH_PFX_HIGH  = 3'd4;
  localparam logic [2:0] PH_PFX_LAST  = 3'd5;
  localparam logic [2:0] PH_DATA      = 3'd6;
  localparam logic [2:0] PH_DONE      = 3'd7;

  // prefix kinds
  localparam logic [1:0] KIND_FIXED = 2'd0;
  localparam logic [1:0] KIND_LL    = 2'd1;
  localparam logic [1:0] KIND_LLL   = 2'd2;

  typedef struct packed {
    logic       last_of_message;
    logic       last_of_field;
    logic [7:0] data_byte;
    logic [7:0] field_number;
  } ifd_item_t;

  // Attribute ROM, element 1 first: [9:0] fixed length, [11:10] kind, [12] packed
  localparam logic [15:0] ATTR_ROM [FIELD_MAX] = '{
    16'h0008, 16'h1400, 16'h1006, 16'h100C, 16'h000C, 16'h000C, 16'h000A, 16'h0008,
    16'h0008, 16'h0008, 16'h1006, 16'h1006, 16'h1004, 16'h1004, 16'h1004, 16'h0004,
    16'h0004, 16'h0004, 16'h0003, 16'h0003, 16'h0003, 16'h1003, 16'h1003, 16'h0003,
    16'h1002, 16'h1002, 16'h0001, 16'h0006, 16'h0000, 16'h0000, 16'h0000, 16'h1400,
    16'h0400, 16'h0400, 16'h1400, 16'h1800, 16'h000C, 16'h0006, 16'h0002, 16'h0003,
    16'h0008, 16'h000F, 16'h0028, 16'h0400, 16'h0400, 16'h0800, 16'h0800, 16'h0800,
    16'h0003, 16'h0003, 16'h0003, 16'h0008, 16'h1010, 16'h0800, 16'h0800, 16'h0800,
    16'h0800, 16'h0800, 16'h0800, 16'h1800, 16'h0800, 16'h0800, 16'h0800, 16'h0008,
    16'h0800, 16'h0001, 16'h0800, 16'h0800, 16'h0800, 16'h0003, 16'h0800, 16'h0800,
    16'h0006, 16'h000A, 16'h000A, 16'h000A, 16'h000A, 16'h000A, 16'h000A, 16'h000A,
    16'h000A, 16'h000C, 16'h000C, 16'h000C, 16'h000C, 16'h0010, 16'h0010, 16'h0010,
    16'h0010, 16'h002A, 16'h0001, 16'h0800, 16'h0800, 16'h0007, 16'h002A, 16'h0008,
    16'h0010, 16'h0800, 16'h0400, 16'h0400, 16'h0400, 16'h0400, 16'h0400, 16'h0800,
    16'h0800, 16'h0800, 16'h0800, 16'h0800, 16'h0800, 16'h0800, 16'h0800, 16'h0800,
    16'h0800, 16'h0800, 16'h0800, 16'h0800, 16'h0800, 16'h0800, 16'h0800, 16'h0800,
    16'h0800, 16'h0800, 16'h0800, 16'h0800, 16'h0800, 16'h0800, 16'h0800, 16'h0008
  };

  // Widen the high digit before weighting it: 15 * 10 + 15 still fits in 8 bits
  function automatic logic [7:0] bcd_pair(input logic [7:0] b);
    bcd_pair = 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
  endfunction

endpackage

### rtl/ifd_parser.sv
`timescale 1ns / 1ps
module ifd_parser import ifd_pkg::*; #(
  parameter int FIELD_COUNT = FIELD_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [HDR_W-1:0] cfg_wdata,
  input  logic             acc,
  input  logic [7:0]       msg_byte,
  input  logic             start,
  output logic             emit,
  output ifd_item_t        item
);

  localparam logic [7:0] EXT_LIMIT = 8'(FIELD_COUNT);

  logic [2:0]       phase_r, phase_nxt, phase_e;
  logic [5:0]       pos_r, pos_nxt, pos_e, pos_inc;
  logic [63:0]      bm0_r, bm0_nxt, bm0_e;
  logic [63:0]      bm1_r, bm1_nxt, bm1_e;
  logic [6:0]       cur_r, cur_nxt, cur_e;
  logic [LEN_W-1:0] br_r, br_nxt, br_e, br_dec;
  logic [7:0]       pv_r, pv_nxt, pv_e;
  logic [HDR_W-1:0] hdr_r;

  logic [FIELD_MAX-1:0] pres, nz, cand, later_v;
  logic [7:0]  lim, from;
  logic        found;
  logic [6:0]  fidx;
  logic [15:0] fattr, cattr;
  logic [9:0]  flen;
  logic [14:0] v_raw, v_pk;
  logic [LEN_W-1:0] v_len;
  logic        later;

  // Zero-length fixed elements never need bytes
  always_comb begin
    for (int i = 0; i < FIELD_MAX; i++) begin
      nz[i] = !(ATTR_ROM[i][11:10] == KIND_FIXED && ATTR_ROM[i][9:0] == 10'd0);
    end
  end

  always_comb begin
    if (start) begin
      phase_e = (hdr_r != '0) ? PH_HEADER : PH_PRIMARY;
      pos_e = '0; bm0_e = '0; bm1_e = '0; cur_e = '0; br_e = '0; pv_e = '0;
    end else begin
      phase_e = phase_r; pos_e = pos_r; bm0_e = bm0_r; bm1_e = bm1_r;
      cur_e = cur_r; br_e = br_r; pv_e = pv_r;
    end
  end

  // Bitmap shift-in and field presence
  always_comb begin
    bm0_nxt = bm0_e;
    bm1_nxt = bm1_e;
    if (phase_e == PH_PRIMARY)   bm0_nxt = {bm0_e[55:0], msg_byte};
    if (phase_e == PH_SECONDARY) bm1_nxt = {bm1_e[55:0], msg_byte};
    lim  = bm0_nxt[63] ? EXT_LIMIT : 8'd64;
    from = (phase_e == PH_PRIMARY || phase_e == PH_SECONDARY) ? 8'd1 : 8'(cur_e) + 8'd1;
    for (int i = 0; i < FIELD_MAX; i++) begin
      pres[i]    = (i < 64) ? bm0_nxt[63-(i%64)] : bm1_nxt[127-i];
      cand[i]    = pres[i] && nz[i] && (8'(i) >= from) && (8'(i) < lim);
      later_v[i] = pres[i] && (8'(i) > 8'(cur_e)) && (8'(i) < lim);
    end
    later = |later_v;
    found = 1'b0;
    fidx  = '0;
    for (int i = FIELD_MAX - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found = 1'b1;
        fidx  = 7'(i);
      end
    end
    fattr = ATTR_ROM[fidx];
    flen  = fattr[12] ? 10'((11'(fattr[9:0]) + 11'd1) >> 1) : fattr[9:0];
  end

  // Prefix length
  always_comb begin
    cattr = ATTR_ROM[cur_e];
    if (cattr[11:10] == KIND_LLL)
      v_raw = 15'(bcd_pair(pv_e)) * 15'd100 + 15'(bcd_pair(msg_byte));
    else
      v_raw = 15'(bcd_pair(msg_byte));
    v_pk  = cattr[12] ? 15'((16'(v_raw) + 16'd1) >> 1) : v_raw;
    v_len = (v_pk > 15'(LEN_MAX)) ? LEN_MAX : v_pk[LEN_W-1:0];
  end

  always_comb begin
    phase_nxt = phase_e;
    pos_nxt   = pos_e;
    cur_nxt   = cur_e;
    br_nxt    = br_e;
    pv_nxt    = pv_e;
    emit      = 1'b0;
    item      = '0;
    pos_inc   = pos_e + 6'd1;
    br_dec    = (br_e != '0) ? br_e - 1'b1 : br_e;
    item.field_number = 8'(cur_e) + 8'd1;
    item.data_byte    = msg_byte;
    unique case (phase_e)
      PH_HEADER: begin
        if (pos_inc >= hdr_r || pos_inc == '0) begin
          pos_nxt = '0; phase_nxt = PH_PRIMARY;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      PH_PRIMARY, PH_SECONDARY: begin
        pos_nxt = pos_inc;
        if (pos_inc >= 6'(BITMAP_BYTES)) begin
          pos_nxt = '0;
          if (phase_e == PH_PRIMARY && bm0_nxt[63]) phase_nxt = PH_SECONDARY;
          else phase_nxt = PH_IDLE; // replaced by advance below
        end
      end
      PH_PFX_HIGH: begin
        pv_nxt = msg_byte; phase_nxt = PH_PFX_LAST;
      end
      PH_PFX_LAST: begin
        pv_nxt = '0;
        if (v_len != '0) begin
          br_nxt = v_len; phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        emit   = 1'b1;
        br_nxt = br_dec;
        if (br_dec == '0) begin
          item.last_of_field   = 1'b1;
          item.last_of_message = !later;
        end
      end
      default: ;
    endcase
    // Advance to the next present element that needs bytes
    if ((phase_e == PH_PRIMARY || phase_e == PH_SECONDARY) && phase_nxt == PH_IDLE ||
        phase_e == PH_PFX_LAST && v_len == '0 ||
        phase_e == PH_DATA && br_dec == '0) begin
      if (found) begin
        cur_nxt = fidx;
        priority case (fattr[11:10])
          KIND_FIXED: begin br_nxt = LEN_W'(flen); phase_nxt = PH_DATA; end
          KIND_LLL:   phase_nxt = PH_PFX_HIGH;
          default:    phase_nxt = PH_PFX_LAST;
        endcase
      end else begin
        phase_nxt = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; pos_r <= '0; bm0_r <= '0; bm1_r <= '0;
      cur_r <= '0; br_r <= '0; pv_r <= '0; hdr_r <= HDR_RESET;
    end else begin
      if (cfg_we) hdr_r <= cfg_wdata;
      if (acc) begin
        phase_r <= phase_nxt; pos_r <= pos_nxt; bm0_r <= bm0_nxt; bm1_r <= bm1_nxt;
        cur_r <= cur_nxt; br_r <= br_nxt; pv_r <= pv_nxt;
      end
    end
  end

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE && !(acc && start) |=> phase_r == PH_DONE)
    else $error("done phase left without a start");
  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> br_r != '0)
    else $error("data phase with zero remaining");
  a_hdr_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PRIMARY || phase_r == PH_SECONDARY |-> pos_r < 6'(BITMAP_BYTES))
    else $error("bitmap position out of range");

endmodule

### rtl/ifd_queue.sv
`timescale 1ns / 1ps
module ifd_queue import ifd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ifd_item_t push_item,
  output logic      not_full,
  input  logic      pop,
  output logic      head_valid,
  output ifd_item_t head_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ifd_item_t       mem_r [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;
  logic            do_pop;

  assign not_full   = cnt_r < (AW+1)'(DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_item  = mem_r[rp_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full)
    else $error("push into full queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH))
    else $error("queue count out of range");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count missed a push");

endmodule

### rtl/iso8583_field_deframer.sv
`timescale 1ns / 1ps
// ISO 8583 field deframer. Feed one message byte per beat on the in_ channel,
// with in_tuser high on the first byte of each message. The block skips the
// header (cfg_wdata, reset 15 bytes), stores the primary bitmap and, when its
// bit 1 is set, the secondary bitmap, then walks the present elements in
// ascending order. Each content byte leaves on the out_ channel with its
// element number; length prefixes are swallowed and zero-length elements
// produce nothing. Every input beat is taken while the queue has room: the next
// present element is found by a combinational priority search over the bitmaps
// plus an attribute ROM lookup, so one byte per clock is sustained until the
// four-entry result queue fills, and the input keeps flowing while the output
// stalls until four results wait. Write the header length only while idle.
module iso8583_field_deframer import ifd_pkg::*; #(
  parameter int FIELD_COUNT = FIELD_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [HDR_W-1:0] cfg_wdata,      // header_bytes
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,       // message_byte
  input  logic             in_tuser,       // start_of_message
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,      // [7:0] field_number, [15:8] data_byte
  output logic             out_tuser,      // last_of_field
  output logic             out_tlast       // last_of_message
);

  logic      acc, emit, not_full;
  ifd_item_t item, head;

  // Accept a beat whenever the queue has room for its possible result
  assign in_tready = not_full;
  assign acc       = in_tvalid && in_tready;

  ifd_parser #(.FIELD_COUNT(FIELD_COUNT)) u_parser (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .acc, .msg_byte(in_tdata), .start(in_tuser),
    .emit, .item
  );

  ifd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n,
    .push(acc && emit), .push_item(item), .not_full,
    .pop(out_tready), .head_valid(out_tvalid), .head_item(head)
  );

  assign out_tdata = {head.data_byte, head.field_number};
  assign out_tuser = head.last_of_field;
  assign out_tlast = head.last_of_message;

  a_last_implies_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("message end without field end");
  a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:0] >= 8'd2)
    else $error("field number below two");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled beat changed");

endmodule
